@@ rtl/lfts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfts_pkg: shared types and constants of the junction turn sequencer
// Register widths and reset values, register indexes, turn and phase codes.
// ----------------------------------------------------------------------------
package lfts_pkg;

    // Default widths of the sensor readings and the wheel speeds
    localparam int SENSOR_BITS_DEF = 10;
    localparam int SPEED_BITS_DEF  = 16;

    // Configuration register widths
    localparam int SPD_CFG_W  = 14;
    localparam int THR_W      = 11;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [SPD_CFG_W-1:0] BASE_SPEED_RST    = SPD_CFG_W'(894);
    localparam logic [SPD_CFG_W-1:0] TURN_GAIN_RST     = SPD_CFG_W'(768);
    localparam logic [THR_W-1:0]     ON_THRESHOLD_RST  = THR_W'(717);
    localparam logic [THR_W-1:0]     OFF_THRESHOLD_RST = THR_W'(512);

    // Threshold scale: thresholds are Q1.10
    localparam int THR_FRAC = 10;

    // Signed width that holds base +/- gain without overflow
    localparam int SPD_SUM_W = SPD_CFG_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SPEED    = 2'd0,
        CFG_TURN_GAIN     = 2'd1,
        CFG_ON_THRESHOLD  = 2'd2,
        CFG_OFF_THRESHOLD = 2'd3
    } cfg_reg_t;

    // Turn kind, the command code taken modulo 4
    typedef enum logic [1:0] {
        TURN_STRAIGHT = 2'd0,
        TURN_RIGHT    = 2'd1,
        TURN_REVERSE  = 2'd2,
        TURN_LEFT     = 2'd3
    } turn_t;

    // Raw command codes that start a turn
    localparam logic [2:0] CODE_LEFT     = 3'b111;
    localparam logic [2:0] CODE_STRAIGHT = 3'b000;
    localparam logic [2:0] CODE_RIGHT    = 3'b001;
    localparam logic [2:0] CODE_REVERSE  = 3'b010;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b000_0001,
        PH_LEAVE  = 7'b000_0010,
        PH_OFFC   = 7'b000_0100,
        PH_ONC    = 7'b000_1000,
        PH_REAL1  = 7'b001_0000,
        PH_ALLOFF = 7'b010_0000,
        PH_REAL2  = 7'b100_0000
    } phase_t;

endpackage

@@ rtl/lfts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfts_cmd_if / lfts_res_if: item channels of the junction turn sequencer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lfts_cmd_if #(
    parameter int SENSOR_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic signed [2:0]      turn_code;
    logic                   right_path_seen;
    logic [SENSOR_BITS-1:0] left_side_raw;
    logic [SENSOR_BITS-1:0] right_side_raw;
    logic [SENSOR_BITS-1:0] center_raw;

    modport source (
        output valid, mode, turn_code, right_path_seen,
               left_side_raw, right_side_raw, center_raw,
        input  ready
    );

    modport sink (
        input  valid, mode, turn_code, right_path_seen,
               left_side_raw, right_side_raw, center_raw,
        output ready
    );
endinterface

interface lfts_res_if #(
    parameter int SPEED_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;
    logic                         turn_active;
    logic                         turn_done;
    logic [1:0]                   heading_out;

    modport source (
        output valid, left_speed, right_speed, turn_active, turn_done, heading_out,
        input  ready
    );

    modport sink (
        input  valid, left_speed, right_speed, turn_active, turn_done, heading_out,
        output ready
    );
endinterface

@@ rtl/line_follower_turn_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_turn_sequencer_top: junction turn sequencer of a line follower
// Starts a turn on a command item and steps its phases on sensor samples,
// giving the wheel speeds of each phase and the robot's heading.
// ----------------------------------------------------------------------------
// Usage:
//   cmd    : input items. mode 0 starts a turn (turn_code, right_path_seen);
//            mode 1 is a sensor sample (three raw readings, inverted here).
//   result : one item per input item: left/right wheel speeds (signed Q8.8),
//            turn_active, turn_done and the heading after the item.
//   cfg_*  : register write port; write only while no item is in flight.
// Timing:
//   An accepted item lands in an input register; its result is computed in
//   one pass and is loaded into the result register, which drives result. Turn
//   state is updated when that register is loaded, so while result is not held
//   a new item is taken every cycle: one item per clock sustained, set by the single input/result register pair.
// Reset:
//   Phase returns to idle, heading to north, registers to their defaults,
//   and both item registers empty.
// Stall:
//   While result is held, the finished item waits in the result register
//   and one more item may wait in the input register; cmd.ready then drops.
// ----------------------------------------------------------------------------
module line_follower_turn_sequencer_top #(
    parameter int SENSOR_BITS = lfts_pkg::SENSOR_BITS_DEF,
    parameter int SPEED_BITS  = lfts_pkg::SPEED_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lfts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lfts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    lfts_cmd_if.sink                           cmd,
    lfts_res_if.source                         result
);
    import lfts_pkg::*;

    // Common scale for strength and threshold compares
    localparam int STR_W  = SENSOR_BITS + 1;
    localparam int CMP_W  = SENSOR_BITS + THR_FRAC + 1;
    // Working width for the speed saturation
    localparam int CALC_W = (SPEED_BITS > SPD_SUM_W) ? SPEED_BITS : SPD_SUM_W;
    localparam logic signed [CALC_W-1:0] SPD_HI =
        signed'({{(CALC_W - SPEED_BITS + 1){1'b0}}, {(SPEED_BITS - 1){1'b1}}});
    localparam logic signed [CALC_W-1:0] SPD_LO = ~SPD_HI;

    // Configuration registers
    logic [SPD_CFG_W-1:0] base_speed_reg;
    logic [SPD_CFG_W-1:0] turn_gain_reg;
    logic [THR_W-1:0]     on_threshold_reg;
    logic [THR_W-1:0]     off_threshold_reg;

    // Input register
    logic                   in_valid_reg;
    logic                   mode_reg;
    logic [2:0]             code_reg;
    logic                   right_path_reg;
    logic [SENSOR_BITS-1:0] left_raw_reg;
    logic [SENSOR_BITS-1:0] right_raw_reg;
    logic [SENSOR_BITS-1:0] center_raw_reg;

    // Turn state
    phase_t     phase_reg, phase_next;
    turn_t      turn_reg, turn_next;
    logic [1:0] heading_reg, heading_next;

    // Result register
    logic                         res_valid_reg;
    logic signed [SPEED_BITS-1:0] left_speed_reg, left_speed_next;
    logic signed [SPEED_BITS-1:0] right_speed_reg, right_speed_next;
    logic                         active_reg, active_next;
    logic                         done_reg, done_next;

    logic advance;
    logic process;

    logic [STR_W-1:0]  str_left, str_right, str_center;
    logic              left_off, right_off, center_off, center_on, sides_off;
    logic [CMP_W-1:0]  on_scaled, off_scaled;
    logic signed [SPD_SUM_W-1:0] base_s, gain_s, ls_raw, rs_raw;
    turn_t             start_turn;

    function automatic logic signed [SPEED_BITS-1:0] sat_speed(
        input logic signed [SPD_SUM_W-1:0] v
    );
        logic signed [CALC_W-1:0] w;
        w = CALC_W'(v);
        if (w > SPD_HI) begin
            w = SPD_HI;
        end
        else if (w < SPD_LO) begin
            w = SPD_LO;
        end
        return w[SPEED_BITS-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] scale_strength(input logic [STR_W-1:0] s);
        return {s, {THR_FRAC{1'b0}}};
    endfunction

    // Hand-shake: the result stage moves when empty or taken
    assign advance   = !res_valid_reg || result.ready;
    assign cmd.ready = !in_valid_reg || advance;
    assign process   = in_valid_reg && advance;

    // Strength is full scale minus the raw reading
    assign str_left   = {1'b1, {SENSOR_BITS{1'b0}}} - {1'b0, left_raw_reg};
    assign str_right  = {1'b1, {SENSOR_BITS{1'b0}}} - {1'b0, right_raw_reg};
    assign str_center = {1'b1, {SENSOR_BITS{1'b0}}} - {1'b0, center_raw_reg};

    assign on_scaled  = {on_threshold_reg, {SENSOR_BITS{1'b0}}};
    assign off_scaled = {off_threshold_reg, {SENSOR_BITS{1'b0}}};

    assign left_off   = scale_strength(str_left) < off_scaled;
    assign right_off  = scale_strength(str_right) < off_scaled;
    assign center_off = scale_strength(str_center) < off_scaled;
    assign center_on  = scale_strength(str_center) > on_scaled;
    assign sides_off  = left_off && right_off;

    assign base_s     = signed'(SPD_SUM_W'(base_speed_reg));
    assign gain_s     = signed'(SPD_SUM_W'(turn_gain_reg));
    assign start_turn = turn_t'(code_reg[1:0]);

    always_comb
    begin
        phase_next       = phase_reg;
        turn_next        = turn_reg;
        heading_next     = heading_reg;
        ls_raw           = '0;
        rs_raw           = '0;
        active_next      = 1'b0;
        done_next        = 1'b0;

        if (!mode_reg) begin
            // Start item: ignore unused codes, else load the turn
            if (code_reg inside {CODE_LEFT, CODE_STRAIGHT, CODE_RIGHT, CODE_REVERSE}) begin
                turn_next    = start_turn;
                heading_next = heading_reg + code_reg[1:0];
                active_next  = 1'b1;
                case (start_turn)
                    TURN_STRAIGHT: phase_next = PH_LEAVE;
                    TURN_REVERSE:  phase_next = right_path_reg ? PH_OFFC : PH_ALLOFF;
                    default:       phase_next = PH_OFFC;
                endcase
            end
        end
        else if (phase_reg != PH_IDLE) begin
            active_next = 1'b1;

            // Wheel speeds of the current phase
            if (phase_reg == PH_LEAVE) begin
                ls_raw = base_s;
                rs_raw = base_s;
            end
            else if (turn_reg == TURN_LEFT) begin
                ls_raw = base_s - gain_s;
                rs_raw = base_s + gain_s;
            end
            else if (turn_reg == TURN_RIGHT) begin
                ls_raw = base_s + gain_s;
                rs_raw = base_s - gain_s;
            end
            else begin
                ls_raw = base_s;
                rs_raw = -base_s;
            end

            // Exit test on this same sample
            case (phase_reg)
                PH_LEAVE:
                begin
                    if (sides_off) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                PH_OFFC:
                begin
                    if (center_off) begin
                        phase_next = (turn_reg == TURN_REVERSE) ? PH_REAL1 : PH_ONC;
                    end
                end
                PH_ONC:
                begin
                    if (center_on) begin
                        phase_next = PH_LEAVE;
                    end
                end
                PH_REAL1:
                begin
                    if (sides_off && center_on) begin
                        phase_next = PH_ALLOFF;
                    end
                end
                PH_ALLOFF:
                begin
                    if (sides_off && center_off) begin
                        phase_next = PH_REAL2;
                    end
                end
                PH_REAL2:
                begin
                    if (sides_off && center_on) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        left_speed_next  = sat_speed(ls_raw);
        right_speed_next = sat_speed(rs_raw);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_speed_reg    <= BASE_SPEED_RST;
            turn_gain_reg     <= TURN_GAIN_RST;
            on_threshold_reg  <= ON_THRESHOLD_RST;
            off_threshold_reg <= OFF_THRESHOLD_RST;
        end
        else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_BASE_SPEED:    base_speed_reg    <= cfg_wdata[SPD_CFG_W-1:0];
                CFG_TURN_GAIN:     turn_gain_reg     <= cfg_wdata[SPD_CFG_W-1:0];
                CFG_ON_THRESHOLD:  on_threshold_reg  <= cfg_wdata[THR_W-1:0];
                CFG_OFF_THRESHOLD: off_threshold_reg <= cfg_wdata[THR_W-1:0];
                default:           base_speed_reg    <= base_speed_reg;
            endcase
        end
    end

    // Control: item valid flags and turn state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            turn_reg      <= TURN_STRAIGHT;
            heading_reg   <= 2'd0;
        end
        else begin
            // Hold the input item until the result stage takes it
            if (cmd.valid && cmd.ready) begin
                in_valid_reg <= 1'b1;
            end
            else if (process) begin
                in_valid_reg <= 1'b0;
            end

            // Drop the result once taken; load a new one on process
            if (process) begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready) begin
                res_valid_reg <= 1'b0;
            end

            // Advance the turn state only when an item is processed
            if (process) begin
                phase_reg   <= phase_next;
                turn_reg    <= turn_next;
                heading_reg <= heading_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready) begin
            mode_reg       <= cmd.mode;
            code_reg       <= cmd.turn_code;
            right_path_reg <= cmd.right_path_seen;
            left_raw_reg   <= cmd.left_side_raw;
            right_raw_reg  <= cmd.right_side_raw;
            center_raw_reg <= cmd.center_raw;
        end
        if (process) begin
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
            active_reg      <= active_next;
            done_reg        <= done_next;
        end
    end

    // Heading is stored with the result so a stalled item keeps its value
    logic [1:0] heading_res_reg;

    always_ff @(posedge clk)
    begin
        if (process) begin
            heading_res_reg <= heading_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.left_speed  = left_speed_reg;
    assign result.right_speed = right_speed_reg;
    assign result.turn_active = active_reg;
    assign result.turn_done   = done_reg;
    assign result.heading_out = heading_res_reg;

endmodule

@@ rtl/lfts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfts_checker: port-level checks of the junction turn sequencer
// Watches the result channel; bound to the top level below.
// ----------------------------------------------------------------------------
module lfts_checker #(
    parameter int SPEED_BITS = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [SPEED_BITS-1:0] left_speed,
    input logic signed [SPEED_BITS-1:0] right_speed,
    input logic                         turn_active,
    input logic                         turn_done
);

    // A completed turn is still reported as active
    a_done_active: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && turn_done |-> turn_active)
        else $error("turn_done without turn_active");

    // Outside a turn the wheels stand still
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !turn_active |-> left_speed == '0 && right_speed == '0)
        else $error("nonzero speed outside a turn");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its speeds
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(left_speed) && $stable(right_speed))
        else $error("result changed while stalled");

endmodule

bind line_follower_turn_sequencer_top lfts_checker #(
    .SPEED_BITS (SPEED_BITS)
) u_lfts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .left_speed  (result.left_speed),
    .right_speed (result.right_speed),
    .turn_active (result.turn_active),
    .turn_done   (result.turn_done)
);
